// ----- design/quaternion_arithmetic_unit_top_macros.svh -----
// assertion macros for the quaternion arithmetic unit checker
`ifndef QUATERNION_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define QUATERNION_ARITHMETIC_UNIT_TOP_MACROS_SVH

// consequent checked in the same cycle
`define QAU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define QAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/qau_pkg.sv -----
// shared constants and operation codes of the quaternion arithmetic unit
`timescale 1ns / 1ps
`default_nettype none
package qau_pkg;

    localparam int FRAC_BITS_DEF       = 14;
    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int LIMIT_W             = 15;
    localparam int WEIGHT_W            = 15;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd1;

    typedef enum logic [2:0] {
        OP_MUL   = 3'd0,
        OP_ROT   = 3'd1,
        OP_NLERP = 3'd2,
        OP_NORM  = 3'd3,
        OP_CONJ  = 3'd4
    } op_t;

endpackage
`default_nettype wire

// ----- design/qau_sqrt.sv -----
// pipelined integer square root, one result bit per stage, with sideband
`timescale 1ns / 1ps
`default_nettype none
module qau_sqrt #(
    parameter int SQW    = 38,
    parameter int SIDE_W = 8
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     en,
    input  wire logic                     in_valid,
    input  wire logic [SQW-1:0]           in_radicand,
    input  wire logic [SIDE_W-1:0]        in_side,
    output logic                          out_valid,
    output logic [(SQW+1)/2-1:0]          out_root,
    output logic [SIDE_W-1:0]             out_side
);

    localparam int LW = (SQW + 1) / 2;

    logic [SQW-1:0]    v_reg    [LW];
    logic [SQW-1:0]    res_reg  [LW];
    logic [SIDE_W-1:0] side_reg [LW];
    logic              val_reg  [LW];

    for (genvar k = 0; k < LW; k++) begin : g_stage
        localparam logic [SQW-1:0] BIT = SQW'(64'd1 << (2 * (LW - 1 - k)));
        logic [SQW-1:0]    v_in;
        logic [SQW-1:0]    res_in;
        logic [SIDE_W-1:0] side_in;
        logic              val_in;
        logic [SQW-1:0]    trial;
        logic [SQW-1:0]    v_next;
        logic [SQW-1:0]    res_next;

        if (k == 0) begin : g_first
            assign v_in    = in_radicand;
            assign res_in  = '0;
            assign side_in = in_side;
            assign val_in  = in_valid;
        end else begin : g_next
            assign v_in    = v_reg[k-1];
            assign res_in  = res_reg[k-1];
            assign side_in = side_reg[k-1];
            assign val_in  = val_reg[k-1];
        end

        always_comb
        begin
            trial = res_in + BIT;
            if (v_in >= trial)
            begin
                v_next   = v_in - trial;
                res_next = (res_in >> 1) + BIT;
            end
            else
            begin
                v_next   = v_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                val_reg[k] <= 1'b0;
            else if (en)
                val_reg[k] <= val_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[k]    <= v_next;
                res_reg[k]  <= res_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = val_reg[LW-1];
    assign out_root  = res_reg[LW-1][LW-1:0];
    assign out_side  = side_reg[LW-1];

endmodule
`default_nettype wire

// ----- design/qau_div.sv -----
// pipelined four-lane restoring divider over a shared divisor, with sideband
`timescale 1ns / 1ps
`default_nettype none
module qau_div #(
    parameter int NUMW   = 33,
    parameter int DENW   = 19,
    parameter int QW     = 15,
    parameter int SIDE_W = 8
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic [3:0][NUMW-1:0]      in_num,
    input  wire logic [DENW-1:0]           in_den,
    input  wire logic [SIDE_W-1:0]         in_side,
    output logic                           out_valid,
    output logic [3:0][QW-1:0]             out_quot,
    output logic [SIDE_W-1:0]              out_side
);

    localparam int CMPW = (NUMW > DENW + QW) ? NUMW : DENW + QW;

    logic [3:0][NUMW-1:0] rem_reg  [QW];
    logic [3:0][QW-1:0]   q_reg    [QW];
    logic [DENW-1:0]      den_reg  [QW];
    logic [SIDE_W-1:0]    side_reg [QW];
    logic                 val_reg  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int J = QW - 1 - k;
        logic [3:0][NUMW-1:0] rem_in;
        logic [3:0][QW-1:0]   q_in;
        logic [DENW-1:0]      den_in;
        logic [SIDE_W-1:0]    side_in;
        logic                 val_in;
        logic [CMPW-1:0]      dsh;
        logic [3:0][NUMW-1:0] rem_next;
        logic [3:0][QW-1:0]   q_next;

        if (k == 0) begin : g_first
            assign rem_in  = in_num;
            assign q_in    = '0;
            assign den_in  = in_den;
            assign side_in = in_side;
            assign val_in  = in_valid;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
            assign val_in  = val_reg[k-1];
        end

        always_comb
        begin
            dsh = CMPW'(den_in) << J;
            for (int l = 0; l < 4; l++)
            begin
                if (CMPW'(rem_in[l]) >= dsh)
                begin
                    rem_next[l] = NUMW'(CMPW'(rem_in[l]) - dsh);
                    q_next[l]   = q_in[l] | (QW'(1) << J);
                end
                else
                begin
                    rem_next[l] = rem_in[l];
                    q_next[l]   = q_in[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                val_reg[k] <= 1'b0;
            else if (en)
                val_reg[k] <= val_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                q_reg[k]    <= q_next;
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = val_reg[QW-1];
    assign out_quot  = q_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule
`default_nettype wire

// ----- design/quaternion_arithmetic_unit_top.sv -----
// top level of the fixed-point quaternion arithmetic unit
// usage
// - input channel: in_valid with operation, quaternions a and b and blend_weight;
//   a request is taken at a clock edge with in_valid high and in_stall low
// - output channel: out_valid with r_w..r_z, degenerate and saturated; the
//   receiver holds out_stall high to keep the current result in place
// - one request enters per cycle when the output is not stalled
// - pipeline: five front stages for the products and sums, one stage per root bit
//   in the square-root pipeline (COMPONENT_WIDTH + 3 stages, 32 at the widest),
//   one setup stage, FRAC_BITS + 1 divider stages and the output register
// - every operation runs through the same depth, so results leave in order
// - a stalled result stalls the whole pipeline, and in_stall follows it in
//   the same cycle; nothing is lost or repeated
// - reset empties the pipeline and sets degenerate_limit to 1
// - cfg_write_enable writes degenerate_limit; write it only while idle
`timescale 1ns / 1ps
`default_nettype none
module quaternion_arithmetic_unit_top
    import qau_pkg::*;
#(
    parameter int FRAC_BITS       = FRAC_BITS_DEF,
    parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write_enable,
    input  wire logic [LIMIT_W-1:0]                cfg_write_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [2:0]                        operation,
    input  wire logic signed [COMPONENT_WIDTH-1:0] a_w,
    input  wire logic signed [COMPONENT_WIDTH-1:0] a_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] a_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0] a_z,
    input  wire logic signed [COMPONENT_WIDTH-1:0] b_w,
    input  wire logic signed [COMPONENT_WIDTH-1:0] b_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] b_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0] b_z,
    input  wire logic [WEIGHT_W-1:0]               blend_weight,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [COMPONENT_WIDTH-1:0]      r_w,
    output logic signed [COMPONENT_WIDTH-1:0]      r_x,
    output logic signed [COMPONENT_WIDTH-1:0]      r_y,
    output logic signed [COMPONENT_WIDTH-1:0]      r_z,
    output logic                                   degenerate,
    output logic                                   saturated
);

    localparam int W   = COMPONENT_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int PW  = 2 * W;
    localparam int HW  = 2 * W + 3;
    localparam int XW  = (HW > F + 3) ? HW : F + 3;
    localparam int TW  = F + 1;
    localparam int BW  = W + F + 2;
    localparam int BW1 = BW + 1;
    localparam int NW  = W + 2;
    localparam int SW  = 2 * NW + 2;
    localparam int SQW = (SW > 64) ? 64 : SW;
    localparam int LW  = (SQW + 1) / 2;
    localparam int DW  = NW + F + 1;
    localparam int QW  = F + 1;

    localparam logic signed [XW-1:0] MAXV = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] MINV = ~MAXV;
    localparam logic signed [HW-1:0] HALF_H = $signed(HW'(64'd1 << (F - 1)));
    localparam logic signed [BW1-1:0] HALF_B = $signed(BW1'(64'd1 << (F - 1)));
    localparam logic [31:0] ONE32 = 32'(64'd1 << F);
    localparam logic [TW-1:0] ONE_T = TW'(ONE32);
    localparam logic signed [XW-1:0] ONE_X = $signed(XW'(ONE32));

    typedef struct packed {
        logic               norm;
        logic               sat;
        logic [3:0][W-1:0]  r;
        logic [3:0][NW-1:0] n;
    } side_a_t;

    typedef struct packed {
        logic              norm;
        logic              deg;
        logic              sat;
        logic [3:0][W-1:0] r;
        logic [3:0]        neg;
    } side_b_t;

    function automatic logic ovf_f(input logic signed [XW-1:0] v);
        return (v > MAXV) || (v < MINV);
    endfunction

    function automatic logic signed [W-1:0] clip_f(input logic signed [XW-1:0] v);
        logic signed [W-1:0] res;
        if (v > MAXV)
            res = MAXV[W-1:0];
        else if (v < MINV)
            res = MINV[W-1:0];
        else
            res = v[W-1:0];
        return res;
    endfunction

    logic en;
    logic [LIMIT_W-1:0] limit_reg;

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_write_enable)
            limit_reg <= cfg_write_data;
    end

    // stage 0: input capture
    logic                v0_reg;
    logic [2:0]          op0_reg;
    logic signed [W-1:0] a0_reg  [4];
    logic signed [W-1:0] b0_reg  [4];
    logic signed [W-1:0] pb0_reg [4];
    logic [TW-1:0]       t0_reg;
    logic [31:0]         bw_ext;
    logic                is_rot_in;

    assign bw_ext    = 32'(blend_weight);
    assign is_rot_in = (operation == OP_ROT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (en)
            v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op0_reg    <= operation;
            a0_reg[0]  <= a_w;
            a0_reg[1]  <= a_x;
            a0_reg[2]  <= a_y;
            a0_reg[3]  <= a_z;
            b0_reg[0]  <= b_w;
            b0_reg[1]  <= b_x;
            b0_reg[2]  <= b_y;
            b0_reg[3]  <= b_z;
            pb0_reg[0] <= is_rot_in ? '0 : b_w;
            pb0_reg[1] <= b_x;
            pb0_reg[2] <= b_y;
            pb0_reg[3] <= b_z;
            t0_reg     <= (bw_ext > ONE32) ? ONE_T : TW'(bw_ext);
        end
    end

    // stage 1: first products and blend products
    logic                 v1_reg;
    logic [2:0]           op1_reg;
    logic signed [W-1:0]  a1_reg  [4];
    logic signed [PW-1:0] m1_reg  [4][4];
    logic signed [BW-1:0] ba1_reg [4];
    logic signed [BW-1:0] bb1_reg [4];
    logic signed [TW:0]   wa_s;
    logic signed [TW:0]   wb_s;

    assign wa_s = $signed({1'b0, ONE_T - t0_reg});
    assign wb_s = $signed({1'b0, t0_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= v0_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg <= op0_reg;
            for (int i = 0; i < 4; i++)
            begin
                a1_reg[i]  <= a0_reg[i];
                ba1_reg[i] <= a0_reg[i] * wa_s;
                bb1_reg[i] <= b0_reg[i] * wb_s;
                for (int j = 0; j < 4; j++)
                    m1_reg[i][j] <= a0_reg[i] * pb0_reg[j];
            end
        end
    end

    // stage 2: hamilton sums, dot sign, blend
    logic signed [HW-1:0]  mx    [4][4];
    logic signed [HW-1:0]  hsum  [4];
    logic signed [HW-1:0]  hrnd  [4];
    logic signed [HW-1:0]  dsum;
    logic signed [BW1-1:0] sp    [4];
    logic signed [BW1-1:0] sm    [4];
    logic signed [NW-1:0]  nsel  [4];
    logic signed [W-1:0]   hclip [4];
    logic [3:0]            hovf;
    logic                  flip;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                mx[i][j] = HW'(m1_reg[i][j]);
        hsum[0] = mx[0][0] - mx[1][1] - mx[2][2] - mx[3][3];
        hsum[1] = mx[0][1] + mx[1][0] + mx[2][3] - mx[3][2];
        hsum[2] = mx[0][2] - mx[1][3] + mx[2][0] + mx[3][1];
        hsum[3] = mx[0][3] + mx[1][2] - mx[2][1] + mx[3][0];
        dsum    = mx[0][0] + mx[1][1] + mx[2][2] + mx[3][3];
        flip    = dsum[HW-1];
        for (int i = 0; i < 4; i++)
        begin
            hrnd[i]  = (hsum[i] + HALF_H) >>> F;
            hclip[i] = clip_f(XW'(hrnd[i]));
            hovf[i]  = ovf_f(XW'(hrnd[i]));
            sp[i]    = BW1'(ba1_reg[i]) + BW1'(bb1_reg[i]) + HALF_B;
            sm[i]    = BW1'(ba1_reg[i]) - BW1'(bb1_reg[i]) + HALF_B;
            if (op1_reg == OP_NLERP)
                nsel[i] = NW'((flip ? sm[i] : sp[i]) >>> F);
            else
                nsel[i] = NW'(a1_reg[i]);
        end
    end

    logic                 v2_reg;
    logic [2:0]           op2_reg;
    logic signed [W-1:0]  a2_reg  [4];
    logic signed [W-1:0]  hs2_reg [4];
    logic                 hov2_reg;
    logic signed [NW-1:0] n2_reg  [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op2_reg  <= op1_reg;
            hov2_reg <= |hovf;
            for (int i = 0; i < 4; i++)
            begin
                a2_reg[i]  <= a1_reg[i];
                hs2_reg[i] <= hclip[i];
                n2_reg[i]  <= nsel[i];
            end
        end
    end

    // stage 3: second rotate products and squares
    logic                 v3_reg;
    logic [2:0]           op3_reg;
    logic signed [W-1:0]  a3_reg  [4];
    logic signed [W-1:0]  hs3_reg [4];
    logic                 hov3_reg;
    logic signed [NW-1:0] n3_reg  [4];
    logic signed [PW-1:0] p3_reg  [4][4];
    logic [2*NW-1:0]      sq3_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op3_reg  <= op2_reg;
            hov3_reg <= hov2_reg;
            for (int i = 0; i < 4; i++)
            begin
                a3_reg[i]  <= a2_reg[i];
                hs3_reg[i] <= hs2_reg[i];
                n3_reg[i]  <= n2_reg[i];
                sq3_reg[i] <= (2*NW)'(n2_reg[i] * n2_reg[i]);
                for (int j = 0; j < 4; j++)
                    p3_reg[i][j] <= hs2_reg[i] * a2_reg[j];
            end
        end
    end

    // stage 4: rotate sums, sum of squares, direct results
    logic signed [HW-1:0] px [4][4];
    logic signed [HW-1:0] rsum [3];
    logic signed [HW-1:0] rrnd [3];
    logic signed [W-1:0]  rclip [3];
    logic [2:0]           rovf;
    logic signed [W-1:0]  cclip [3];
    logic [2:0]           covf;
    logic [SW-1:0]        ssum;
    logic [SQW-1:0]       s_cl;
    side_a_t              sa_next;

    if (SW > SQW) begin : g_clamp
        assign s_cl = (|ssum[SW-1:SQW]) ? '1 : ssum[SQW-1:0];
    end else begin : g_noclamp
        assign s_cl = ssum;
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                px[i][j] = HW'(p3_reg[i][j]);
        rsum[0] = -px[0][1] + px[1][0] - px[2][3] + px[3][2];
        rsum[1] = -px[0][2] + px[1][3] + px[2][0] - px[3][1];
        rsum[2] = -px[0][3] - px[1][2] + px[2][1] + px[3][0];
        for (int k = 0; k < 3; k++)
        begin
            rrnd[k]  = (rsum[k] + HALF_H) >>> F;
            rclip[k] = clip_f(XW'(rrnd[k]));
            rovf[k]  = ovf_f(XW'(rrnd[k]));
            cclip[k] = clip_f(-XW'(a3_reg[k+1]));
            covf[k]  = ovf_f(-XW'(a3_reg[k+1]));
        end
        ssum = SW'(sq3_reg[0]) + SW'(sq3_reg[1]) + SW'(sq3_reg[2]) + SW'(sq3_reg[3]);
        sa_next = '0;
        for (int i = 0; i < 4; i++)
            sa_next.n[i] = n3_reg[i];
        case (op3_reg)
            OP_MUL:
            begin
                for (int i = 0; i < 4; i++)
                    sa_next.r[i] = hs3_reg[i];
                sa_next.sat = hov3_reg;
            end
            OP_ROT:
            begin
                for (int k = 0; k < 3; k++)
                    sa_next.r[k+1] = rclip[k];
                sa_next.sat = hov3_reg || (|rovf);
            end
            OP_NLERP, OP_NORM:
                sa_next.norm = 1'b1;
            OP_CONJ:
            begin
                sa_next.r[0] = a3_reg[0];
                for (int k = 0; k < 3; k++)
                    sa_next.r[k+1] = cclip[k];
                sa_next.sat = |covf;
            end
            default:
                sa_next.norm = 1'b0;
        endcase
    end

    logic           v4_reg;
    logic [SQW-1:0] s4_reg;
    side_a_t        sa4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_reg  <= s_cl;
            sa4_reg <= sa_next;
        end
    end

    // square root of the sum of squares
    logic                       sq_valid;
    logic [LW-1:0]              sq_root;
    logic [$bits(side_a_t)-1:0] sq_side;
    side_a_t                    sa_out;

    qau_sqrt #(
        .SQW    (SQW),
        .SIDE_W ($bits(side_a_t))
    ) u_sqrt (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (v4_reg),
        .in_radicand (s4_reg),
        .in_side     (sa4_reg),
        .out_valid   (sq_valid),
        .out_root    (sq_root),
        .out_side    (sq_side)
    );

    assign sa_out = sq_side;

    // stage 5: degenerate test and dividends
    logic [NW-1:0]        nmag [4];
    logic [3:0][DW-1:0]   num_next;
    side_b_t              sb_next;

    always_comb
    begin
        sb_next      = '0;
        sb_next.norm = sa_out.norm;
        sb_next.sat  = sa_out.sat;
        sb_next.r    = sa_out.r;
        sb_next.deg  = (sq_root == '0) || (32'(sq_root) < 32'(limit_reg));
        for (int i = 0; i < 4; i++)
        begin
            sb_next.neg[i] = sa_out.n[i][NW-1];
            nmag[i]        = sa_out.n[i][NW-1] ? (~sa_out.n[i] + 1'b1) : sa_out.n[i];
            num_next[i]    = (DW'(nmag[i]) << F) + DW'(sq_root >> 1);
        end
    end

    logic               v5_reg;
    logic [LW-1:0]      den5_reg;
    logic [3:0][DW-1:0] num5_reg;
    side_b_t            sb5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den5_reg <= sq_root;
            num5_reg <= num_next;
            sb5_reg  <= sb_next;
        end
    end

    // divide each component by the length
    logic                       dv_valid;
    logic [3:0][QW-1:0]         dv_quot;
    logic [$bits(side_b_t)-1:0] dv_side;
    side_b_t                    sb_out;

    qau_div #(
        .NUMW   (DW),
        .DENW   (LW),
        .QW     (QW),
        .SIDE_W ($bits(side_b_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v5_reg),
        .in_num    (num5_reg),
        .in_den    (den5_reg),
        .in_side   (sb5_reg),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_side  (dv_side)
    );

    assign sb_out = dv_side;

    // final selection and output register
    logic signed [XW-1:0] qs  [4];
    logic signed [XW-1:0] qv  [4];
    logic signed [W-1:0]  fin [4];
    logic                 fin_sat;
    logic                 fin_deg;

    always_comb
    begin
        fin_sat = sb_out.sat;
        fin_deg = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            qs[i]  = $signed(XW'(dv_quot[i]));
            qv[i]  = sb_out.neg[i] ? -qs[i] : qs[i];
            fin[i] = sb_out.r[i];
        end
        if (sb_out.norm)
        begin
            if (sb_out.deg)
            begin
                fin_deg = 1'b1;
                fin[0]  = clip_f(ONE_X);
                fin[1]  = '0;
                fin[2]  = '0;
                fin[3]  = '0;
                fin_sat = ovf_f(ONE_X);
            end
            else
            begin
                fin_sat = 1'b0;
                for (int i = 0; i < 4; i++)
                begin
                    fin[i]  = clip_f(qv[i]);
                    fin_sat = fin_sat || ovf_f(qv[i]);
                end
            end
        end
    end

    logic                out_valid_reg;
    logic signed [W-1:0] r_reg [4];
    logic                deg_reg;
    logic                sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
                r_reg[i] <= fin[i];
            deg_reg <= fin_deg;
            sat_reg <= fin_sat;
        end
    end

    assign out_valid  = out_valid_reg;
    assign r_w        = r_reg[0];
    assign r_x        = r_reg[1];
    assign r_y        = r_reg[2];
    assign r_z        = r_reg[3];
    assign degenerate = deg_reg;
    assign saturated  = sat_reg;

endmodule
`default_nettype wire

// ----- design/qau_checker.sv -----
// port-level checker of the quaternion arithmetic unit, with its bind
`timescale 1ns / 1ps
`default_nettype none
`include "quaternion_arithmetic_unit_top_macros.svh"
module qau_checker #(
    parameter int COMPONENT_WIDTH = 16
) (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic signed [COMPONENT_WIDTH-1:0] r_w,
    input wire logic signed [COMPONENT_WIDTH-1:0] r_x,
    input wire logic signed [COMPONENT_WIDTH-1:0] r_y,
    input wire logic signed [COMPONENT_WIDTH-1:0] r_z,
    input wire logic                              degenerate,
    input wire logic                              saturated
);

    logic held;
    assign held = out_valid && out_stall;

    // input is stalled exactly when a result is held
    `QAU_ASSERT_SAME(a_stall_follows, 1'b1, in_stall == held, "in_stall does not track held result")

    // held result keeps its payload
    `QAU_ASSERT_NEXT(a_hold, held, out_valid && $stable(r_w) && $stable(r_x) && $stable(r_y) && $stable(r_z) && $stable(degenerate) && $stable(saturated), "held result changed")

    // degenerate normalization gives the identity with a zero vector part
    `QAU_ASSERT_SAME(a_identity, out_valid && degenerate, r_x == '0 && r_y == '0 && r_z == '0, "degenerate result not identity")

    // an accepted request on a stalled side never happens
    `QAU_ASSERT_SAME(a_no_take_stalled, in_valid && held, in_stall, "request taken while output held")

endmodule

bind quaternion_arithmetic_unit_top qau_checker #(
    .COMPONENT_WIDTH (COMPONENT_WIDTH)
) u_qau_checker (.*);
`default_nettype wire

// ----- tb/tb_quaternion_arithmetic_unit_top.sv -----
// testbench for the quaternion arithmetic unit: directed table and random requests against a predictor
`timescale 1ns / 1ps
module tb_quaternion_arithmetic_unit_top;
    import qau_pkg::*;

    localparam int FB = 14;
    localparam int CW = 16;
    localparam int LATENCY = CW + FB + 11;

    typedef struct packed {
        logic [2:0] op;
        logic signed [15:0] aw, ax, ay, az, bw, bx, by, bz;
        logic [14:0] wt;
    } quat_req_t;

    typedef struct packed {
        logic signed [15:0] rw, rx, ry, rz;
        logic degen, sat;
    } quat_res_t;

    typedef struct {
        quat_req_t req;
        logic typed;
        quat_res_t res;
    } table_row_t;

    logic clk, rst_n;
    logic cfg_write_enable;
    logic [LIMIT_W-1:0] cfg_write_data;
    logic in_valid, in_stall, out_valid, out_stall;
    logic [2:0] operation;
    logic signed [15:0] a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z;
    logic [14:0] blend_weight;
    logic signed [15:0] r_w, r_x, r_y, r_z;
    logic degenerate, saturated;

    quaternion_arithmetic_unit_top u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_enable(cfg_write_enable), .cfg_write_data(cfg_write_data),
        .in_valid(in_valid), .in_stall(in_stall), .operation(operation),
        .a_w(a_w), .a_x(a_x), .a_y(a_y), .a_z(a_z),
        .b_w(b_w), .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .blend_weight(blend_weight),
        .out_valid(out_valid), .out_stall(out_stall),
        .r_w(r_w), .r_x(r_x), .r_y(r_y), .r_z(r_z),
        .degenerate(degenerate), .saturated(saturated)
    );

    logic [14:0] limit_model;
    quat_res_t expected_q[$];
    int mismatches = 0;
    int results_seen = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int op_count[8];

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #50ms;
        $display("timeout");
        $display("Mismatches found");
        $finish;
    end

    function automatic longint clip16(longint v, inout logic f);
        if (v > 32767)
        begin
            f = 1'b1;
            return 32767;
        end
        if (v < -32768)
        begin
            f = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    // hamilton product with one rounding per component, no clip
    function automatic void hamilton(input longint p[4], input longint q[4],
                                     output longint r[4]);
        longint s[4];
        s[0] = p[0]*q[0] - p[1]*q[1] - p[2]*q[2] - p[3]*q[3];
        s[1] = p[0]*q[1] + p[1]*q[0] + p[2]*q[3] - p[3]*q[2];
        s[2] = p[0]*q[2] - p[1]*q[3] + p[2]*q[0] + p[3]*q[1];
        s[3] = p[0]*q[3] + p[1]*q[2] - p[2]*q[1] + p[3]*q[0];
        for (int i = 0; i < 4; i++)
            r[i] = (s[i] + (64'sd1 <<< (FB-1))) >>> FB;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic void unit_length(input longint c[4], output longint r[4],
                                        inout logic dg, inout logic sf);
        longint unsigned s, len, m, qv;
        s = 0;
        for (int i = 0; i < 4; i++)
        begin
            m = (c[i] < 0) ? -c[i] : c[i];
            s += m * m;
        end
        len = root_floor(s);
        if (len == 0 || len < limit_model)
        begin
            dg = 1'b1;
            r[0] = clip16(64'sd1 <<< FB, sf);
            r[1] = 0;
            r[2] = 0;
            r[3] = 0;
            return;
        end
        for (int i = 0; i < 4; i++)
        begin
            m = (c[i] < 0) ? -c[i] : c[i];
            qv = ((m << FB) + len / 2) / len;
            r[i] = clip16((c[i] < 0) ? -longint'(qv) : longint'(qv), sf);
        end
    endfunction

    function automatic quat_res_t predict_quat(quat_req_t q);
        longint a[4], b[4], r[4], p[4], ca[4], t1[4], c[4];
        longint t, dot, bb;
        logic dg, sf;
        quat_res_t o;
        dg = 0;
        sf = 0;
        r = '{0, 0, 0, 0};
        a = '{q.aw, q.ax, q.ay, q.az};
        b = '{q.bw, q.bx, q.by, q.bz};
        t = (q.wt > (1 << FB)) ? (1 << FB) : q.wt;
        case (q.op)
            OP_MUL:
            begin
                hamilton(a, b, t1);
                for (int i = 0; i < 4; i++)
                    r[i] = clip16(t1[i], sf);
            end
            OP_ROT:
            begin
                p = '{0, b[1], b[2], b[3]};
                ca = '{a[0], -a[1], -a[2], -a[3]};
                hamilton(a, p, t1);
                for (int i = 0; i < 4; i++)
                    t1[i] = clip16(t1[i], sf);
                hamilton(t1, ca, c);
                for (int i = 1; i < 4; i++)
                    r[i] = clip16(c[i], sf);
            end
            OP_NLERP:
            begin
                dot = 0;
                for (int i = 0; i < 4; i++)
                    dot += a[i] * b[i];
                for (int i = 0; i < 4; i++)
                begin
                    bb = (dot < 0) ? -b[i] : b[i];
                    c[i] = (a[i]*((1 << FB) - t) + bb*t + (1 << (FB-1))) >>> FB;
                end
                unit_length(c, r, dg, sf);
            end
            OP_NORM:
                unit_length(a, r, dg, sf);
            OP_CONJ:
            begin
                r[0] = a[0];
                for (int i = 1; i < 4; i++)
                    r[i] = clip16(-a[i], sf);
            end
            default:
                ;
        endcase
        o.rw = r[0];
        o.rx = r[1];
        o.ry = r[2];
        o.rz = r[3];
        o.degen = dg;
        o.sat = sf;
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // result side: check accepted results and drive stall
    always @(posedge clk)
    begin
        quat_res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_q.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                e = expected_q.pop_front();
                if (r_w !== e.rw) report_mismatch("r_w", r_w, e.rw);
                if (r_x !== e.rx) report_mismatch("r_x", r_x, e.rx);
                if (r_y !== e.ry) report_mismatch("r_y", r_y, e.ry);
                if (r_z !== e.rz) report_mismatch("r_z", r_z, e.rz);
                if (degenerate !== e.degen) report_mismatch("degenerate", degenerate, e.degen);
                if (saturated !== e.sat) report_mismatch("saturated", saturated, e.sat);
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic write_limit(logic [14:0] v);
        cfg_write_enable <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_enable <= 1'b0;
        limit_model = v;
    endtask

    task automatic drain_pipe();
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // sends one request, holding it until accepted; valid stays up if another follows
    task automatic send_request(quat_req_t q, logic typed, quat_res_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= q.op;
        a_w <= q.aw; a_x <= q.ax; a_y <= q.ay; a_z <= q.az;
        b_w <= q.bw; b_x <= q.bx; b_y <= q.by; b_z <= q.bz;
        blend_weight <= q.wt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        op_count[q.op]++;
        expected_q.push_back(typed ? want : predict_quat(q));
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_comp(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(32767) - 16384;
            2: return $urandom_range(32) - 16;
            default: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    function automatic quat_req_t random_req();
        quat_req_t q;
        int m;
        m = $urandom_range(9);
        m = (m < 3) ? 0 : (m < 7) ? 1 : (m < 9) ? 2 : 3;
        q.op = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
        q.aw = rand_comp(m); q.ax = rand_comp(m); q.ay = rand_comp(m); q.az = rand_comp(m);
        q.bw = rand_comp(m); q.bx = rand_comp(m); q.by = rand_comp(m); q.bz = rand_comp(m);
        q.wt = ($urandom_range(9) == 0) ? 15'($urandom) : 15'($urandom_range(16384));
        return q;
    endfunction

    table_row_t rows[$];
    localparam quat_req_t ZQ = '0;

    initial
    begin
        quat_req_t q;
        table_row_t row;
        int pct_send[4] = '{0, 55, 0, 7};
        int pct_stall[4] = '{0, 0, 55, 7};
        logic [14:0] limits[4] = '{15'd0, 15'd32767, 15'd16384, 15'd200};
        rst_n = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_write_data = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        {operation, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, blend_weight} = '0;
        limit_model = LIMIT_RESET;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero normalize is degenerate, identity times identity, conjugate extremes, undefined opcodes
        row.req = ZQ; row.req.op = OP_NORM; row.typed = 1;
        row.res = '{16'sd16384, 0, 0, 0, 1'b1, 1'b0};
        rows.push_back(row);
        row.req = ZQ; row.req.op = OP_MUL; row.req.aw = 16384; row.req.bw = 16384;
        row.res = '{16'sd16384, 0, 0, 0, 1'b0, 1'b0};
        rows.push_back(row);
        row.req = ZQ; row.req.op = OP_CONJ; row.req.aw = -32768;
        row.req.ax = -32768; row.req.ay = 32767; row.req.az = 0;
        row.res = '{-16'sd32768, 16'sd32767, -16'sd32767, 0, 1'b0, 1'b1};
        rows.push_back(row);
        for (int opc = 5; opc < 8; opc++)
        begin
            row.req = '1; row.req.op = opc[2:0];
            row.res = '0;
            rows.push_back(row);
        end
        row.typed = 0;
        row.req = '{OP_MUL, 32767, 32767, 32767, 32767, -32768, 32767, -32768, 32767, 15'd0};
        rows.push_back(row);
        row.req = '{OP_MUL, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 0};
        rows.push_back(row);
        row.req = '{OP_ROT, 32767, -32768, 32767, -32768, 5, 32767, 32767, -32768, 0};
        rows.push_back(row);
        row.req = '{OP_ROT, 11585, 0, 0, 11585, 0, 16384, 0, 0, 0};
        rows.push_back(row);
        row.req = '{OP_NLERP, 16384, 0, 0, 0, 0, 16384, 0, 0, 15'd8192};
        rows.push_back(row);
        row.req = '{OP_NLERP, 16384, 0, 0, 0, -16384, 0, 0, 0, 15'd8192};
        rows.push_back(row);
        row.req = '{OP_NLERP, 16384, 100, 0, 0, 0, 16384, 0, 0, 15'd0};
        rows.push_back(row);
        row.req = '{OP_NLERP, 16384, 100, 0, 0, 0, 16384, 0, 0, 15'd16384};
        rows.push_back(row);
        row.req = '{OP_NLERP, 3, 4, 0, 0, 9, 9, 9, 9, 15'h7fff};
        rows.push_back(row);
        row.req = '{OP_NLERP, 16384, 0, 0, 0, -16384, 0, 0, 0, 15'd16384};
        rows.push_back(row);
        row.req = '{OP_NORM, 0, 1, 0, 0, 0, 0, 0, 0, 0};
        rows.push_back(row);
        row.req = '{OP_NORM, 1, 0, 0, 0, 0, 0, 0, 0, 0};
        rows.push_back(row);
        row.req = '{OP_NORM, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0};
        rows.push_back(row);
        row.req = '{OP_NORM, 3, -4, 0, 0, 0, 0, 0, 0, 0};
        rows.push_back(row);
        row.req = '{OP_CONJ, 32767, 1, -1, 32767, 0, 0, 0, 0, 0};
        rows.push_back(row);
        foreach (rows[i])
            send_request(rows[i].req, rows[i].typed, rows[i].res);
        idle_input();
        drain_pipe();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_limit(limits[ph]);
            send_idle_pct = pct_send[ph];
            stall_pct = pct_stall[ph];
            for (int n = 0; n < 125; n++)
            begin
                q = random_req();
                send_request(q, 1'b0, '0);
            end
            idle_input();
            drain_pipe();
        end
        write_limit(15'd1);
        row.req = '{OP_NORM, 0, 0, 1, 0, 0, 0, 0, 0, 0};
        send_request(row.req, 1'b0, '0);
        idle_input();
        stall_pct = 0;
        drain_pipe();

        $display("%0d results checked: mul %0d rot %0d nlerp %0d norm %0d conj %0d",
                 results_seen, op_count[0], op_count[1], op_count[2], op_count[3], op_count[4]);
        $display("four limit settings with idle and stall phases");
        if (mismatches == 0 && expected_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
